>>> src/arp_cache_with_aging_core_macros.svh
// Assertion macros for the ARP cache core.
// Depends on nothing; the including module provides clk and rst.
`ifndef ARP_CACHE_WITH_AGING_CORE_MACROS_SVH
`define ARP_CACHE_WITH_AGING_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ARPC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ARPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ARPC_ASSERT_SAME(lbl, ante, cons, msg)
`define ARPC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> src/arpc_pkg.sv
// Shared types, codes and reset values for the ARP cache core.
// No dependencies.
package arpc_pkg;

  typedef logic [31:0] ip_t;
  typedef logic [47:0] mac_t;
  typedef logic [7:0]  age_t;

  localparam int ENTRIES_DEF = 8;

  typedef enum logic [1:0] {
    ES_EMPTY   = 2'd0,
    ES_PENDING = 2'd1,
    ES_STABLE  = 2'd2,
    ES_REREQ   = 2'd3
  } entry_st_t;

  localparam logic [1:0] ACT_TICK    = 2'd0;
  localparam logic [1:0] ACT_UPDATE  = 2'd1;
  localparam logic [1:0] ACT_RESOLVE = 2'd2;

  localparam logic [1:0] STAT_OK          = 2'd0;
  localparam logic [1:0] STAT_PENDING     = 2'd1;
  localparam logic [1:0] STAT_FULL        = 2'd2;
  localparam logic [1:0] STAT_NOT_UNICAST = 2'd3;

  localparam logic [2:0] REG_LOCAL_IP      = 3'd0;
  localparam logic [2:0] REG_SUBNET_MASK   = 3'd1;
  localparam logic [2:0] REG_MAX_AGE       = 3'd2;
  localparam logic [2:0] REG_REREQUEST_AGE = 3'd3;
  localparam logic [2:0] REG_MAX_PENDING   = 3'd4;

  localparam ip_t  LOCAL_IP_RST      = 32'h0000_0000;
  localparam ip_t  SUBNET_MASK_RST   = 32'hFFFF_FF00;
  localparam age_t MAX_AGE_RST       = 8'd240;
  localparam age_t REREQUEST_AGE_RST = 8'd228;
  localparam age_t MAX_PENDING_RST   = 8'd2;
  localparam age_t AGE_SAT           = 8'hFF;

  localparam ip_t IP_ALL_ONES  = 32'hFFFF_FFFF;
  localparam ip_t IP_MCAST_MSK = 32'hF000_0000;
  localparam ip_t IP_MCAST_VAL = 32'hE000_0000;

endpackage

>>> src/arpc_addr_check.sv
// Classifies an IPv4 address as not unicast (zero, limited broadcast,
// multicast, subnet broadcast). Depends on arpc_pkg.
module arpc_addr_check (
  input  arpc_pkg::ip_t ip,
  input  arpc_pkg::ip_t local_ip,
  input  arpc_pkg::ip_t subnet_mask,
  output logic          not_unicast
);
  import arpc_pkg::*;

  ip_t host_bits;
  logic special;
  logic subnet_bcast;

  always_comb begin
    host_bits    = ~subnet_mask;
    special      = (ip == '0) || (ip == IP_ALL_ONES) ||
                   ((ip & IP_MCAST_MSK) == IP_MCAST_VAL);
    subnet_bcast = (ip != local_ip) &&
                   ((ip & subnet_mask) == (local_ip & subnet_mask)) &&
                   ((ip & host_bits) == host_bits);
    not_unicast  = special || subnet_bcast;
  end

endmodule

>>> src/arp_cache_with_aging_core.sv
// ARP cache top level: sequencer, entry store and configuration registers.
// Depends on arpc_pkg, arpc_addr_check and the assertion macro header.
//
// A word is taken when start is high and busy is low. The result word appears
// on the result ports for one cycle with done high, and it must be taken then:
// there is no stall. busy stays high from the accepting edge until the result
// word is out; update, resolve and tick scan every entry, while a rejected
// address or unknown action ends without a scan. The scan steps one entry per
// cycle through the entry memories (one write and one registered read port) with
// one shared address comparator. A new word may be started in the cycle done is
// high. Configuration must be written while busy is low (not enforced).
`include "arp_cache_with_aging_core_macros.svh"

module arp_cache_with_aging_core #(
  parameter int ENTRIES = arpc_pkg::ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          action,
  input  arpc_pkg::ip_t       ip_addr,
  input  arpc_pkg::mac_t      mac_addr,
  output logic                done,
  output logic [1:0]          status,
  output logic [2:0]          entry_index,
  output arpc_pkg::mac_t      dest_mac,
  output logic                send_request,
  output logic                release_held,
  output logic                drop_held,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import arpc_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CHECK  = 6'b000010,
    S_SCAN   = 6'b000100,
    S_FETCH  = 6'b001000,
    S_DECIDE = 6'b010000,
    S_TICK   = 6'b100000
  } seq_st_t;

  seq_st_t state, state_next;

  // configuration
  ip_t  local_ip, subnet_mask;
  age_t max_age, rerequest_age, max_pending;

  // latched word
  logic [1:0] act_r;
  ip_t        ip_r;
  mac_t       mac_r;

  // entry store
  entry_st_t  entry_state [ENTRIES];
  logic       has_pkt     [ENTRIES];
  ip_t        ip_mem      [ENTRIES];
  mac_t       mac_mem     [ENTRIES];
  age_t       age_mem     [ENTRIES];
  ip_t        ip_q;
  mac_t       mac_q;
  age_t       age_q;

  // scan control
  logic [CNT_W-1:0] cnt;
  logic             scan_end;
  logic             pv;
  logic [IDX_W-1:0] p_idx, rd_addr, sel_idx, ent_sel;
  logic             hit_found, free_found;
  logic [IDX_W-1:0] hit_idx, free_idx;

  entry_st_t st_cur, st_wd, s_eff;
  logic      hp_cur, hp_eff, taken, dropped;
  logic      st_we, hp_we, hp_wd, ip_we, mac_we, age_we;
  age_t      age_wd, age_inc;
  logic      expire;
  logic      nonuni;

  logic       emit;
  logic [1:0] o_status;
  logic [2:0] o_idx;
  mac_t       o_mac;
  logic       o_req, o_rel, o_drop;

  arpc_addr_check u_addr_check (
    .ip          (ip_r),
    .local_ip    (local_ip),
    .subnet_mask (subnet_mask),
    .not_unicast (nonuni)
  );

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign scan_end  = (cnt == CNT_W'(ENTRIES));

  always_comb begin
    sel_idx = hit_found ? hit_idx : free_idx;
    ent_sel = (state == S_FETCH || state == S_DECIDE) ? sel_idx : p_idx;
    if (state == S_FETCH) begin
      rd_addr = sel_idx;
    end else if (cnt < CNT_W'(ENTRIES)) begin
      rd_addr = cnt[IDX_W-1:0];
    end else begin
      rd_addr = '0;
    end
    st_cur  = entry_state[ent_sel];
    hp_cur  = has_pkt[ent_sel];
    taken   = !hit_found && free_found;
    s_eff   = hit_found ? st_cur : ES_EMPTY;
    hp_eff  = hit_found && hp_cur;
    dropped = taken && hp_cur;
    age_inc = (age_q == AGE_SAT) ? age_q : age_q + 8'd1;
    expire  = (age_inc >= max_age) || (st_cur == ES_PENDING && age_inc >= max_pending);
  end

  always_comb begin
    state_next = state;
    st_we  = 1'b0;
    st_wd  = ES_EMPTY;
    hp_we  = 1'b0;
    hp_wd  = 1'b0;
    ip_we  = 1'b0;
    mac_we = 1'b0;
    age_we = 1'b0;
    age_wd = '0;
    emit     = 1'b0;
    o_status = STAT_OK;
    o_idx    = '0;
    o_mac    = '0;
    o_req    = 1'b0;
    o_rel    = 1'b0;
    o_drop   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_CHECK;
      end
      S_CHECK: begin
        case (act_r) inside
          ACT_TICK: state_next = S_TICK;
          ACT_UPDATE, ACT_RESOLVE: begin
            if (nonuni) begin
              emit       = 1'b1;
              o_status   = STAT_NOT_UNICAST;
              state_next = S_IDLE;
            end else begin
              state_next = S_SCAN;
            end
          end
          default: begin
            emit       = 1'b1;
            state_next = S_IDLE;
          end
        endcase
      end
      S_SCAN: begin
        if (scan_end) state_next = S_FETCH;
      end
      S_FETCH: begin
        if (!hit_found && !free_found) begin
          emit       = 1'b1;
          o_status   = STAT_FULL;
          state_next = S_IDLE;
        end else begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        emit       = 1'b1;
        state_next = S_IDLE;
        o_idx      = 3'(sel_idx);
        o_drop     = dropped;
        if (taken) begin
          ip_we  = 1'b1;
          age_we = 1'b1;
          hp_we  = 1'b1;
        end
        if (act_r == ACT_UPDATE) begin
          st_we  = 1'b1;
          st_wd  = ES_STABLE;
          mac_we = 1'b1;
          age_we = 1'b1;
          hp_we  = 1'b1;
          if (hp_eff) begin
            o_rel = 1'b1;
            o_mac = mac_r;
          end
        end else if (s_eff == ES_STABLE || s_eff == ES_REREQ) begin
          o_mac = mac_q;
          if (s_eff == ES_STABLE && age_q >= rerequest_age) begin
            o_req = 1'b1;
            st_we = 1'b1;
            st_wd = ES_REREQ;
          end
        end else begin
          st_we    = 1'b1;
          st_wd    = ES_PENDING;
          hp_we    = 1'b1;
          hp_wd    = 1'b1;
          o_req    = 1'b1;
          o_drop   = dropped || hp_eff;
          o_status = STAT_PENDING;
        end
      end
      S_TICK: begin
        if (pv && st_cur != ES_EMPTY) begin
          age_we = 1'b1;
          age_wd = age_inc;
          st_we  = 1'b1;
          if (expire) begin
            st_wd = ES_EMPTY;
            hp_we = 1'b1;
          end else begin
            st_wd = (st_cur == ES_REREQ) ? ES_STABLE : st_cur;
          end
        end
        if (scan_end) begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer and scan control
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      cnt        <= '0;
      pv         <= 1'b0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else begin
      state <= state_next;
      done  <= emit;
      pv    <= (state == S_SCAN || state == S_TICK) && (cnt < CNT_W'(ENTRIES));
      if (state == S_CHECK) begin
        cnt        <= '0;
        hit_found  <= 1'b0;
        free_found <= 1'b0;
      end else if ((state == S_SCAN || state == S_TICK) && !scan_end) begin
        cnt <= cnt + CNT_W'(1);
      end
      // one entry per cycle through the shared comparator
      if (state == S_SCAN && pv) begin
        if (!hit_found && st_cur != ES_EMPTY && ip_q == ip_r) begin
          hit_found <= 1'b1;
        end
        if (!free_found && (st_cur == ES_EMPTY || st_cur == ES_PENDING)) begin
          free_found <= 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    p_idx <= rd_addr;
    if (state == S_IDLE && start) begin
      act_r <= action;
      ip_r  <= ip_addr;
      mac_r <= mac_addr;
    end
    if (state == S_SCAN && pv) begin
      if (!hit_found && st_cur != ES_EMPTY && ip_q == ip_r) hit_idx <= p_idx;
      if (!free_found && (st_cur == ES_EMPTY || st_cur == ES_PENDING)) free_idx <= p_idx;
    end
    if (emit) begin
      status       <= o_status;
      entry_index  <= o_idx;
      dest_mac     <= o_mac;
      send_request <= o_req;
      release_held <= o_rel;
      drop_held    <= o_drop;
    end
  end

  // entry state and held-packet flags, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        entry_state[i] <= ES_EMPTY;
        has_pkt[i]     <= 1'b0;
      end
    end else begin
      if (st_we) entry_state[ent_sel] <= st_wd;
      if (hp_we) has_pkt[ent_sel] <= hp_wd;
    end
  end

  // entry memories: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (ip_we)  ip_mem[ent_sel]  <= ip_r;
    if (mac_we) mac_mem[ent_sel] <= mac_r;
    if (age_we) age_mem[ent_sel] <= age_wd;
    ip_q  <= ip_mem[rd_addr];
    mac_q <= mac_mem[rd_addr];
    age_q <= age_mem[rd_addr];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      local_ip      <= LOCAL_IP_RST;
      subnet_mask   <= SUBNET_MASK_RST;
      max_age       <= MAX_AGE_RST;
      rerequest_age <= REREQUEST_AGE_RST;
      max_pending   <= MAX_PENDING_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LOCAL_IP:      local_ip      <= cfg_data;
        REG_SUBNET_MASK:   subnet_mask   <= cfg_data;
        REG_MAX_AGE:       max_age       <= cfg_data[7:0];
        REG_REREQUEST_AGE: rerequest_age <= cfg_data[7:0];
        REG_MAX_PENDING:   max_pending   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  `ARPC_ASSERT_SAME(a_done_idle, done, state == S_IDLE, "result word while sequencer busy")
  `ARPC_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted word did not start sequencer")
  `ARPC_ASSERT_SAME(a_release_ok, done && release_held, status == STAT_OK && !send_request, "release with bad status")
  `ARPC_ASSERT_SAME(a_reject_clean, done && status == STAT_NOT_UNICAST, entry_index == '0 && !send_request && !drop_held, "rejected address touched an entry")

endmodule
